/* rtl/core/amt_pkg.sv */
// ----------------------------------------------------------------------------
// amt_pkg
// Shared types and constants of the 3x3 adaptive mean threshold block.
// ----------------------------------------------------------------------------
package amt_pkg;

    localparam int PIX_W    = 8;
    localparam int CNT_W    = 13;
    localparam int CFG_W    = 13;
    localparam int IDX_W    = 3;
    localparam int LINE_W   = 2 * PIX_W;
    localparam int COL_W    = 10;
    localparam int SUM_W    = 12;
    localparam int LIM_W    = 13;
    localparam int NRES     = 4;
    localparam int RCNT_W   = 3;
    localparam int RIDX_W   = 2;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = QPTR_W + 1;

    localparam logic [CNT_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [CNT_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [PIX_W-1:0] OFFSET_RST = 8'd2;
    localparam logic [PIX_W-1:0] HIGH_RST   = 8'd255;
    localparam logic [PIX_W-1:0] LOW_RST    = 8'd0;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [IDX_W-1:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_OFFSET = 3'd2,
        REG_HIGH   = 3'd3,
        REG_LOW    = 3'd4
    } t_reg_idx;

    // per-transaction control carried down the pipeline
    typedef struct packed {
        logic emit;
        logic row_done;
        logic last_row;
        logic frame_done;
        logic xone;
        logic ytop;
    } t_ctl;

    // new window column: top (row y-2), mid (row y-1), bot (row y)
    typedef struct packed {
        t_pix top;
        t_pix mid;
        t_pix bot;
    } t_col;

    // results of one transaction, compacted in output order
    typedef struct packed {
        logic [NRES-1:0]   hit;
        logic [RCNT_W-1:0] cnt;
        logic              frame;
    } t_bundle;

endpackage

/* rtl/core/amt_pixel_if.sv */
// ----------------------------------------------------------------------------
// amt_pixel_if
// Valid/ready channel carrying one grey input pixel per transaction.
// ----------------------------------------------------------------------------
interface amt_pixel_if;
    logic          valid;
    logic          ready;
    amt_pkg::t_pix pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

/* rtl/core/amt_result_if.sv */
// ----------------------------------------------------------------------------
// amt_result_if
// Valid/ready channel carrying one thresholded result per transaction.
// ----------------------------------------------------------------------------
interface amt_result_if;
    logic          valid;
    logic          ready;
    amt_pkg::t_pix level;
    logic          run_end;
    logic          frame_end;

    modport source (output valid, output level, output run_end, output frame_end,
                    input ready);
    modport sink   (input valid, input level, input run_end, input frame_end,
                    output ready);
endinterface

/* rtl/core/amt_line_mem.sv */
// ----------------------------------------------------------------------------
// amt_line_mem
// Line store: one write port, one read port, registered read data.
// Each entry holds {row y-2, row y-1} for one column.
// ----------------------------------------------------------------------------
module amt_line_mem #(
    parameter  int DEPTH = 4096,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [amt_pkg::LINE_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [amt_pkg::LINE_W-1:0] o_rdata
);

    logic [amt_pkg::LINE_W-1:0] r_mem [DEPTH];
    logic [amt_pkg::LINE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/amt_window.sv */
// ----------------------------------------------------------------------------
// amt_window
// 3x3 window register and the four threshold decisions that one
// transaction can need: normal row (A, B) and lowered last row (C, D),
// each at the inner column (A, C) and at the right border (B, D).
// ----------------------------------------------------------------------------
module amt_window (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_shift,
    input  amt_pkg::t_col            i_col,
    input  logic                     i_xone,
    input  amt_pkg::t_pix            i_offset,
    output logic [amt_pkg::NRES-1:0] o_hit
);

    amt_pkg::t_pix r_win [3][3];

    logic [amt_pkg::COL_W-1:0] col_n [3];
    logic [amt_pkg::COL_W-1:0] col_l [3];
    logic [amt_pkg::COL_W-1:0] left_n, left_l;
    logic [amt_pkg::SUM_W-1:0] sum_a, sum_b, sum_c, sum_d;

    // floor(s / 9) <= v  <=>  s <= 9v + 8, with v = centre + offset
    function automatic logic [amt_pkg::LIM_W-1:0] limit(amt_pkg::t_pix ctr,
                                                        amt_pkg::t_pix off);
        logic [amt_pkg::LIM_W-1:0] v;
        v = amt_pkg::LIM_W'(ctr) + amt_pkg::LIM_W'(off);
        return (v << 3) + v + amt_pkg::LIM_W'(8);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (i_shift) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= i_col.top;
            r_win[1][2] <= i_col.mid;
            r_win[2][2] <= i_col.bot;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            col_n[c] = amt_pkg::COL_W'(r_win[0][c]) + amt_pkg::COL_W'(r_win[1][c])
                     + amt_pkg::COL_W'(r_win[2][c]);
            col_l[c] = amt_pkg::COL_W'(r_win[1][c])
                     + (amt_pkg::COL_W'(r_win[2][c]) << 1);
        end
        left_n = i_xone ? col_n[1] : col_n[0];
        left_l = i_xone ? col_l[1] : col_l[0];
        sum_a  = amt_pkg::SUM_W'(left_n) + amt_pkg::SUM_W'(col_n[1])
               + amt_pkg::SUM_W'(col_n[2]);
        sum_b  = amt_pkg::SUM_W'(col_n[1]) + (amt_pkg::SUM_W'(col_n[2]) << 1);
        sum_c  = amt_pkg::SUM_W'(left_l) + amt_pkg::SUM_W'(col_l[1])
               + amt_pkg::SUM_W'(col_l[2]);
        sum_d  = amt_pkg::SUM_W'(col_l[1]) + (amt_pkg::SUM_W'(col_l[2]) << 1);

        o_hit[0] = amt_pkg::LIM_W'(sum_a) <= limit(r_win[1][1], i_offset);
        o_hit[1] = amt_pkg::LIM_W'(sum_b) <= limit(r_win[1][2], i_offset);
        o_hit[2] = amt_pkg::LIM_W'(sum_c) <= limit(r_win[2][1], i_offset);
        o_hit[3] = amt_pkg::LIM_W'(sum_d) <= limit(r_win[2][2], i_offset);
    end

endmodule

/* rtl/core/amt_out_queue.sv */
// ----------------------------------------------------------------------------
// amt_out_queue
// Small queue of per-pixel result bundles and the serializer that sends
// their results one transaction at a time.
// ----------------------------------------------------------------------------
module amt_out_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  amt_pkg::t_bundle           i_bundle,
    input  amt_pkg::t_pix              i_high,
    input  amt_pkg::t_pix              i_low,
    output logic [amt_pkg::QCNT_W-1:0] o_count,
    amt_result_if.source               o_res
);

    amt_pkg::t_bundle                r_q [amt_pkg::QDEPTH];
    logic [amt_pkg::QPTR_W-1:0]      r_wp, r_rp;
    logic [amt_pkg::QCNT_W-1:0]      r_cnt;
    amt_pkg::t_bundle                r_out;
    logic                            r_out_v;
    logic [amt_pkg::RIDX_W-1:0]      r_idx;

    logic last, take, pop;

    assign last = amt_pkg::RCNT_W'(r_idx) == (r_out.cnt - amt_pkg::RCNT_W'(1));
    assign take = r_out_v && o_res.ready;
    assign pop  = (r_cnt != '0) && (!r_out_v || (take && last));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
            r_out_v <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + amt_pkg::QPTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + amt_pkg::QPTR_W'(1);
            end
            r_cnt <= r_cnt + amt_pkg::QCNT_W'(i_push) - amt_pkg::QCNT_W'(pop);
            if (pop) begin
                r_out_v <= 1'b1;
                r_idx   <= '0;
            end else if (take && last) begin
                r_out_v <= 1'b0;
            end else if (take) begin
                r_idx <= r_idx + amt_pkg::RIDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= r_q[r_rp];
        end
    end

    assign o_count         = r_cnt;
    assign o_res.valid     = r_out_v;
    assign o_res.level     = r_out.hit[r_idx] ? i_high : i_low;
    assign o_res.run_end   = last;
    assign o_res.frame_end = last && r_out.frame;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt < amt_pkg::QCNT_W'(amt_pkg::QDEPTH)) || pop)
        else $error("result queue overflow");

    a_idx_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (amt_pkg::RCNT_W'(r_idx) < r_out.cnt))
        else $error("serializer index beyond bundle");

endmodule

/* rtl/core/adaptive_mean_threshold_3x3.sv */
// ----------------------------------------------------------------------------
// adaptive_mean_threshold_3x3
// Streaming 3x3 adaptive mean threshold with replicated borders.
//
//   channel   dir  handshake            payload
//   i_pix     in   valid/ready          pixel[7:0]
//   o_res     out  valid/ready          level[7:0], run_end, frame_end
//   i_cfg_*   in   write enable only    idx[2:0], data[12:0]
//
// One pixel per cycle while i_pix.ready is high; the line store is read when a
// pixel is accepted and written back in the next cycle, as the window updates.
// A pixel's results pass the r_a and r_b registers, the result queue and the
// output register; the output port sends one result per cycle while o_res.ready
// is high, so row-end and last-row pixels (two or four results) hold i_pix.ready
// low while the four-entry result queue fills.
// Reset clears counters, window, queue and registers; line store is not cleared.
// ----------------------------------------------------------------------------
module adaptive_mean_threshold_3x3 #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [amt_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [amt_pkg::CFG_W-1:0] i_cfg_data,
    amt_pixel_if.sink                 i_pix,
    amt_result_if.source              o_res
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int XW = ($clog2(MAX_WIDTH + 1) > amt_pkg::CNT_W) ?
                        $clog2(MAX_WIDTH + 1) : amt_pkg::CNT_W;

    amt_pkg::t_cnt r_width, r_height, r_col, r_row;
    amt_pkg::t_pix r_offset, r_high, r_low;

    logic                         r_a_v, r_b_v;
    amt_pkg::t_ctl                r_a_ctl, r_b_ctl;
    amt_pkg::t_pix                r_a_pix;
    logic [AW-1:0]                r_a_addr;

    logic                         accept;
    logic [XW-1:0]                wd_min, wd, wd_m1;
    amt_pkg::t_cnt                ht_m1;
    amt_pkg::t_ctl                ctl;
    logic [AW-1:0]                raddr;
    logic [amt_pkg::LINE_W-1:0]   rdata;
    amt_pkg::t_pix                up2, up1;
    amt_pkg::t_col                col;
    logic [amt_pkg::NRES-1:0]     hit;
    amt_pkg::t_bundle             bundle;
    logic [amt_pkg::QCNT_W-1:0]   q_cnt, occ;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= amt_pkg::WIDTH_RST;
            r_height <= amt_pkg::HEIGHT_RST;
            r_offset <= amt_pkg::OFFSET_RST;
            r_high   <= amt_pkg::HIGH_RST;
            r_low    <= amt_pkg::LOW_RST;
        end else if (i_cfg_we) begin
            unique case (amt_pkg::t_reg_idx'(i_cfg_idx))
                amt_pkg::REG_WIDTH:  r_width  <= i_cfg_data;
                amt_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                amt_pkg::REG_OFFSET: r_offset <= i_cfg_data[amt_pkg::PIX_W-1:0];
                amt_pkg::REG_HIGH:   r_high   <= i_cfg_data[amt_pkg::PIX_W-1:0];
                amt_pkg::REG_LOW:    r_low    <= i_cfg_data[amt_pkg::PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // position decode
    always_comb begin
        wd_min = (XW'(r_width) > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(r_width);
        wd     = (wd_min < XW'(2)) ? XW'(2) : wd_min;
        wd_m1  = wd - XW'(1);
        ht_m1  = (r_height < amt_pkg::CNT_W'(2)) ? amt_pkg::CNT_W'(1)
                                                 : r_height - amt_pkg::CNT_W'(1);
        ctl.row_done   = XW'(r_col) >= wd_m1;
        ctl.last_row   = r_row >= ht_m1;
        ctl.frame_done = ctl.row_done && ctl.last_row;
        ctl.emit       = (r_row != '0) && (r_col != '0);
        ctl.xone       = r_col == amt_pkg::CNT_W'(1);
        ctl.ytop       = r_row == amt_pkg::CNT_W'(1);
    end

    assign occ          = q_cnt + amt_pkg::QCNT_W'(r_a_v) + amt_pkg::QCNT_W'(r_b_v);
    assign i_pix.ready  = occ < amt_pkg::QCNT_W'(amt_pkg::QDEPTH);
    assign accept       = i_pix.valid && i_pix.ready;
    assign raddr        = AW'(r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            r_a_v <= accept;
            r_b_v <= r_a_v;
            if (accept) begin
                if (ctl.frame_done) begin
                    r_col <= '0;
                    r_row <= '0;
                end else if (ctl.row_done) begin
                    r_col <= '0;
                    r_row <= r_row + amt_pkg::CNT_W'(1);
                end else begin
                    r_col <= r_col + amt_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_ctl  <= ctl;
            r_a_pix  <= i_pix.pixel;
            r_a_addr <= raddr;
        end
        r_b_ctl <= r_a_ctl;
    end

    // consecutive pixels always touch different columns, so the write-back
    // never meets the read of the same cycle
    amt_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (r_a_v),
        .i_waddr (r_a_addr),
        .i_wdata ({up1, r_a_pix}),
        .i_re    (accept),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign up2     = r_a_ctl.ytop ? rdata[amt_pkg::PIX_W-1:0]
                                  : rdata[amt_pkg::LINE_W-1:amt_pkg::PIX_W];
    assign up1     = rdata[amt_pkg::PIX_W-1:0];
    assign col.top = up2;
    assign col.mid = up1;
    assign col.bot = r_a_pix;

    amt_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (r_a_v),
        .i_col    (col),
        .i_xone   (r_b_ctl.xone),
        .i_offset (r_offset),
        .o_hit    (hit)
    );

    // order: A, then B at row end or C in last row, then C, D at frame end
    always_comb begin
        bundle.hit[0] = hit[0];
        bundle.hit[1] = r_b_ctl.row_done ? hit[1] : hit[2];
        bundle.hit[2] = hit[2];
        bundle.hit[3] = hit[3];
        bundle.cnt    = amt_pkg::RCNT_W'(1) + amt_pkg::RCNT_W'(r_b_ctl.row_done)
                      + amt_pkg::RCNT_W'(r_b_ctl.last_row)
                      + amt_pkg::RCNT_W'(r_b_ctl.frame_done);
        bundle.frame  = r_b_ctl.frame_done;
    end

    amt_out_queue u_out_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (r_b_v && r_b_ctl.emit),
        .i_bundle (bundle),
        .i_high   (r_high),
        .i_low    (r_low),
        .o_count  (q_cnt),
        .o_res    (o_res)
    );

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_a_v) |-> (raddr != r_a_addr))
        else $error("line store read and write hit the same column");

    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.frame_end) |-> o_res.run_end)
        else $error("frame end on a result that does not close its run");

    a_counts_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ctl.frame_done) |=> (r_col == '0) && (r_row == '0))
        else $error("position not cleared after frame end");

endmodule

/* dv/amt_threshold_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// amt_threshold_checker
// Watches the pixel, result and register ports of the 3x3 adaptive mean
// threshold block. It keeps its own line stores, window and counters, works
// out the results of every accepted pixel, and compares each accepted result
// against the oldest one still due.
// ----------------------------------------------------------------------------
module amt_threshold_checker #(
    parameter int MAX_W = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [amt_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [amt_pkg::CFG_W-1:0] i_cfg_data,
    amt_pixel_if                      i_pix,
    amt_result_if                     i_res,
    output int                        o_errors,
    output int                        o_pending
);

    typedef struct packed {
        amt_pkg::t_pix level;
        logic          run_end;
        logic          frame_end;
    } t_verdict;

    amt_pkg::t_pix above_row  [MAX_W];
    amt_pkg::t_pix recent_row [MAX_W];
    amt_pkg::t_pix win        [9];
    amt_pkg::t_cnt col_pos;
    amt_pkg::t_cnt row_pos;
    amt_pkg::t_cnt width_reg;
    amt_pkg::t_cnt height_reg;
    amt_pkg::t_pix offset_reg;
    amt_pkg::t_pix high_reg;
    amt_pkg::t_pix low_reg;
    t_verdict      levels_due [$];

    // lc/cc/rc pick window columns; lowered replicates the bottom row
    function automatic amt_pkg::t_pix mean_level(input int unsigned lc,
                                                 input int unsigned cc,
                                                 input int unsigned rc,
                                                 input bit lowered);
        int unsigned rows [3];
        int unsigned cols [3];
        int unsigned total;
        int unsigned thr;
        int unsigned r;
        int unsigned q;
        rows[0] = lowered ? 1 : 0;
        rows[1] = lowered ? 2 : 1;
        rows[2] = 2;
        cols[0] = lc;
        cols[1] = cc;
        cols[2] = rc;
        total = 0;
        for (r = 0; r < 3; r++) begin
            for (q = 0; q < 3; q++) begin
                total += 32'(win[rows[r] * 3 + cols[q]]);
            end
        end
        total = total / 9;
        thr = (total >= 32'(offset_reg)) ? total - 32'(offset_reg) : 0;
        return (32'(win[rows[1] * 3 + cc]) >= thr) ? high_reg : low_reg;
    endfunction

    task automatic absorb_pixel(input amt_pkg::t_pix pix);
        int unsigned   wd;
        int unsigned   ht;
        int unsigned   lc;
        int unsigned   k;
        int unsigned   n;
        amt_pkg::t_pix up2;
        amt_pkg::t_pix up1;
        bit            row_done;
        bit            frame_done;
        amt_pkg::t_pix lv [4];
        t_verdict      v;
        wd = 32'(width_reg);
        if (wd < 2) wd = 2;
        if (wd > MAX_W) wd = MAX_W;
        ht = 32'(height_reg);
        if (ht < 2) ht = 2;
        row_done   = col_pos >= wd - 1;
        frame_done = row_done && (row_pos >= ht - 1);

        up2 = '0;
        up1 = '0;
        if (col_pos < MAX_W) begin
            up2 = above_row[col_pos];
            up1 = recent_row[col_pos];
            above_row[col_pos]  = up1;
            recent_row[col_pos] = pix;
        end
        if (row_pos == 1) up2 = up1;

        for (k = 0; k < 3; k++) begin
            win[k * 3]     = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        win[2] = up2;
        win[5] = up1;
        win[8] = pix;

        // row y-1 first, then row y when this is the last row
        n = 0;
        if (row_pos >= 1 && col_pos >= 1) begin
            lc = (col_pos == 1) ? 1 : 0;
            lv[n] = mean_level(lc, 1, 2, 1'b0);
            n++;
            if (row_done) begin
                lv[n] = mean_level(1, 2, 2, 1'b0);
                n++;
            end
            if (frame_done) begin
                lv[n] = mean_level(lc, 1, 2, 1'b1);
                n++;
                lv[n] = mean_level(1, 2, 2, 1'b1);
                n++;
            end else if (row_pos >= ht - 1) begin
                lv[n] = mean_level(lc, 1, 2, 1'b1);
                n++;
            end
        end
        for (k = 0; k < n; k++) begin
            v.level     = lv[k];
            v.run_end   = (k + 1 == n);
            v.frame_end = frame_done && (k + 1 == n);
            levels_due.insert(levels_due.size(), v);
        end

        if (frame_done) begin
            col_pos = '0;
            row_pos = '0;
        end else if (row_done) begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    function automatic void compare_field(input string field, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            o_errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            width_reg  = amt_pkg::WIDTH_RST;
            height_reg = amt_pkg::HEIGHT_RST;
            offset_reg = amt_pkg::OFFSET_RST;
            high_reg   = amt_pkg::HIGH_RST;
            low_reg    = amt_pkg::LOW_RST;
            col_pos    = '0;
            row_pos    = '0;
            foreach (win[i]) win[i] = '0;
            levels_due.delete();
            o_errors   = 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (levels_due.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected result, expected none, actual level %0h",
                             $time, i_res.level);
                end else begin
                    want = levels_due.pop_front();
                    compare_field("level", 32'(want.level), 32'(i_res.level));
                    compare_field("run_end", 32'(want.run_end), 32'(i_res.run_end));
                    compare_field("frame_end", 32'(want.frame_end), 32'(i_res.frame_end));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    amt_pkg::REG_WIDTH:  width_reg  = i_cfg_data;
                    amt_pkg::REG_HEIGHT: height_reg = i_cfg_data;
                    amt_pkg::REG_OFFSET: offset_reg = i_cfg_data[amt_pkg::PIX_W-1:0];
                    amt_pkg::REG_HIGH:   high_reg   = i_cfg_data[amt_pkg::PIX_W-1:0];
                    amt_pkg::REG_LOW:    low_reg    = i_cfg_data[amt_pkg::PIX_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready) absorb_pixel(i_pix.pixel);
        end
        o_pending = levels_due.size();
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives grey frames through the 3x3 adaptive mean threshold block: a few
// directed frames (pixel extremes, offset above the mean, registers changed
// mid-frame, width and height below range), random small frames, then a
// closing stretch without stalls. Both channels stall in random bursts. The
// checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LIMIT = 2000;
    localparam int TAIL  = 8;

    typedef enum int {
        TEX_NOISE,
        TEX_FLAT,
        TEX_BINARY
    } t_texture;

    logic                      i_clk      = 1'b0;
    logic                      i_rst_n    = 1'b0;
    logic                      i_cfg_we   = 1'b0;
    logic [amt_pkg::IDX_W-1:0] i_cfg_idx  = '0;
    logic [amt_pkg::CFG_W-1:0] i_cfg_data = '0;
    bit                        calm       = 1'b0;
    int                        n_errors;
    int                        n_pending;
    int                        stall_cycles;

    amt_pixel_if  pix_if ();
    amt_result_if res_if ();

    always #10 i_clk = ~i_clk;

    adaptive_mean_threshold_3x3 i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    amt_threshold_checker i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .i_res      (res_if),
        .o_errors   (n_errors),
        .o_pending  (n_pending)
    );

    task automatic set_reg(input amt_pkg::t_reg_idx idx, input int unsigned value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[amt_pkg::CFG_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic write_regs(input int unsigned w, input int unsigned h, input int unsigned c,
                              input int unsigned hi, input int unsigned lo);
        set_reg(amt_pkg::REG_WIDTH, w);
        set_reg(amt_pkg::REG_HEIGHT, h);
        set_reg(amt_pkg::REG_OFFSET, c);
        set_reg(amt_pkg::REG_HIGH, hi);
        set_reg(amt_pkg::REG_LOW, lo);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(input amt_pkg::t_pix p);
        if (!calm && $urandom_range(0, 7) == 0) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= p;
        do @(posedge i_clk); while (!pix_if.ready);
    endtask

    // drain every due result, then let the pipeline empty
    task automatic settle();
        pix_if.valid <= 1'b0;
        do @(negedge i_clk); while (n_pending != 0);
        repeat (TAIL) @(posedge i_clk);
    endtask

    function automatic amt_pkg::t_pix texel(input t_texture tex, input int unsigned base);
        int v;
        case (tex)
            TEX_FLAT: begin
                v = int'(base) + int'($urandom_range(0, 12)) - 6;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return amt_pkg::t_pix'(v);
            end
            TEX_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:    return amt_pkg::t_pix'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic run_frame(input int unsigned w, input int unsigned h, input t_texture tex);
        int unsigned base;
        int unsigned i;
        base = $urandom_range(0, 255);
        for (i = 0; i < w * h; i++) send_pixel(texel(tex, base));
    endtask

    task automatic random_frame(inout int unsigned items);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        t_texture    tex;
        w   = $urandom_range(2, 9);
        h   = $urandom_range(2, 6);
        c   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
        tex = t_texture'($urandom_range(0, 2));
        write_regs(w, h, c, $urandom_range(0, 255), $urandom_range(0, 255));
        run_frame(w, h, tex);
        settle();
        items += w * h;
    endtask

    initial begin
        amt_pkg::t_pix corner [4];
        amt_pkg::t_pix spread [6];
        int unsigned   items;
        corner = '{8'h00, 8'hFF, 8'hFF, 8'h00};
        spread = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h80, 8'h7F};
        items  = 0;
        pix_if.valid <= 1'b0;
        pix_if.pixel <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // smallest frame, pixel extremes, zero offset
        write_regs(2, 2, 0, 8'hFF, 8'h00);
        foreach (corner[i]) send_pixel(corner[i]);
        settle();
        items += 4;

        // offset above any mean: threshold clamps to zero
        write_regs(2, 3, 8'hFF, 8'h55, 8'hAA);
        foreach (spread[i]) send_pixel(spread[i]);
        settle();
        items += 6;

        // width shrinks and levels change in the middle of row 1
        write_regs(4, 3, 8, 8'hFF, 8'h00);
        repeat (6) send_pixel(amt_pkg::t_pix'($urandom_range(0, 255)));
        settle();
        write_regs(3, 4, 8'hAA, 8'h00, 8'hFF);
        repeat (7) send_pixel(amt_pkg::t_pix'($urandom_range(0, 255)));
        settle();
        items += 13;

        // width below range clamps to 2, height below range clamps to 2
        write_regs(1, 0, 4, 8'hAA, 8'h55);
        run_frame(2, 2, TEX_NOISE);
        settle();
        write_regs(0, 1, 20, 8'hFF, 8'h00);
        run_frame(2, 2, TEX_FLAT);
        settle();
        items += 8;

        while (items < 75) random_frame(items);

        calm = 1'b1;
        repeat (2) random_frame(items);

        if (n_errors == 0 && n_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
        end
    end

    // no transaction on either channel for too long
    initial begin
        stall_cycles = 0;
        while (stall_cycles < LIMIT) begin
            @(posedge i_clk);
            if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule
